@@ design/bsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfb_pkg
// Shared types and framing constants for the byte-stuffed frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

  // framing control bytes
  localparam logic [7:0] STX = 8'h02;
  localparam logic [7:0] ETX = 8'h03;
  localparam logic [7:0] DLE = 8'h10;

  // reset value of the length register
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // payload item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } pay_item_t;

  // framed stream item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
    logic       aborted;
  } frm_item_t;

  // classified command from the front, one per item that yields output
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] csum;
    logic       stx;
    logic       dle;
    logic       eop;
    logic       abort;
  } cmd_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // emit sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STX,
    PH_DLE,
    PH_DATA,
    PH_CSUM,
    PH_ETX,
    PH_ABORT
  } phase_t;

endpackage

@@ design/bsfb_front.sv @@
// ----------------------------------------------------------------------------
// bsfb_front
// Accepts payload items, tracks packet state and pushes one framing
// command per item that produces output.
// ----------------------------------------------------------------------------
module bsfb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                pay_valid,
  output logic                pay_stall,
  input  bsfb_pkg::pay_item_t pay_item,
  input  logic [7:0]          limit,
  input  bsfb_pkg::q_stat_t   q_stat,
  output logic                push,
  output bsfb_pkg::cmd_t      cmd
);

  logic       mid_packet;
  logic [7:0] payload_count;
  logic [7:0] running_sum;
  logic       overflowed;

  logic       accept;
  logic       over;
  logic [7:0] sum_new;

  // stall only on a full queue
  assign pay_stall = q_stat.full;
  assign accept    = pay_valid && !pay_stall;

  // classify the item
  assign over    = overflowed || (payload_count >= limit);
  assign sum_new = running_sum + pay_item.data_byte;

  always_comb begin
    cmd.data  = pay_item.data_byte;
    cmd.csum  = ~sum_new;
    cmd.stx   = !mid_packet;
    cmd.dle   = (pay_item.data_byte == bsfb_pkg::DLE) ||
                (pay_item.data_byte == bsfb_pkg::STX) ||
                (pay_item.data_byte == bsfb_pkg::ETX);
    cmd.eop   = pay_item.end_of_packet;
    cmd.abort = over;
  end

  // discarded bytes of an overlong packet push nothing
  assign push = accept && (!over || pay_item.end_of_packet);

  // packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_packet    <= 1'b0;
      payload_count <= 8'd0;
      running_sum   <= 8'd0;
      overflowed    <= 1'b0;
    end else if (accept) begin
      if (pay_item.end_of_packet) begin
        mid_packet    <= 1'b0;
        payload_count <= 8'd0;
        running_sum   <= 8'd0;
        overflowed    <= 1'b0;
      end else if (over) begin
        overflowed <= 1'b1;
      end else begin
        mid_packet    <= 1'b1;
        payload_count <= payload_count + 8'd1;
        running_sum   <= sum_new;
      end
    end
  end

endmodule

@@ design/bsfb_queue.sv @@
// ----------------------------------------------------------------------------
// bsfb_queue
// Small command queue that decouples the front from the emit sequencer.
// ----------------------------------------------------------------------------
module bsfb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bsfb_pkg::cmd_t      wr_cmd,
  input  logic                pop,
  output bsfb_pkg::cmd_t      rd_cmd,
  output bsfb_pkg::q_stat_t   q_stat
);

  bsfb_pkg::cmd_t                   entries [bsfb_pkg::QUEUE_DEPTH];
  logic [bsfb_pkg::QPTR_W-1:0]      wr_ptr;
  logic [bsfb_pkg::QPTR_W-1:0]      rd_ptr;
  logic [bsfb_pkg::QCNT_W-1:0]      fill;

  assign q_stat.full  = (fill == bsfb_pkg::QCNT_W'(bsfb_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign rd_cmd       = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ design/bsfb_back.sv @@
// ----------------------------------------------------------------------------
// bsfb_back
// Emit sequencer: expands each command into its framed bytes, one per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module bsfb_back (
  input  logic                clk,
  input  logic                rst,
  input  bsfb_pkg::cmd_t      head_cmd,
  input  bsfb_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                frm_valid,
  input  logic                frm_stall,
  output bsfb_pkg::frm_item_t frm_item
);

  bsfb_pkg::phase_t    phase;
  bsfb_pkg::phase_t    phase_next;
  bsfb_pkg::phase_t    start_phase;
  bsfb_pkg::cmd_t      cur;
  bsfb_pkg::cmd_t      cur_next;
  bsfb_pkg::frm_item_t emit;
  logic                advance;
  logic                step;

  // output stage moves when empty or taken
  assign advance = !frm_valid || !frm_stall;
  assign step    = (phase != bsfb_pkg::PH_IDLE) && advance;

  // first phase of the queue head
  always_comb begin
    if (head_cmd.abort) begin
      start_phase = bsfb_pkg::PH_ABORT;
    end else if (head_cmd.stx) begin
      start_phase = bsfb_pkg::PH_STX;
    end else if (head_cmd.dle) begin
      start_phase = bsfb_pkg::PH_DLE;
    end else begin
      start_phase = bsfb_pkg::PH_DATA;
    end
  end

  // next state
  always_comb begin
    phase_next = phase;
    cur_next   = cur;
    pop        = 1'b0;
    if (phase == bsfb_pkg::PH_IDLE || (step && emit.last_of_run)) begin
      if (!q_stat.empty) begin
        phase_next = start_phase;
        cur_next   = head_cmd;
        pop        = 1'b1;
      end else begin
        phase_next = bsfb_pkg::PH_IDLE;
      end
    end else if (step) begin
      unique case (phase)
        bsfb_pkg::PH_STX:  phase_next = cur.dle ? bsfb_pkg::PH_DLE : bsfb_pkg::PH_DATA;
        bsfb_pkg::PH_DLE:  phase_next = bsfb_pkg::PH_DATA;
        bsfb_pkg::PH_DATA: phase_next = bsfb_pkg::PH_CSUM;
        bsfb_pkg::PH_CSUM: phase_next = bsfb_pkg::PH_ETX;
        default:           phase_next = bsfb_pkg::PH_IDLE;
      endcase
    end
  end

  // byte for the current phase
  always_comb begin
    emit = '0;
    unique case (phase)
      bsfb_pkg::PH_STX: begin
        emit.out_byte = bsfb_pkg::STX;
      end
      bsfb_pkg::PH_DLE: begin
        emit.out_byte = bsfb_pkg::DLE;
      end
      bsfb_pkg::PH_DATA: begin
        emit.out_byte    = cur.data;
        emit.last_of_run = !cur.eop;
      end
      bsfb_pkg::PH_CSUM: begin
        emit.out_byte = cur.csum;
      end
      bsfb_pkg::PH_ETX: begin
        emit.out_byte    = bsfb_pkg::ETX;
        emit.last_of_run = 1'b1;
        emit.frame_end   = 1'b1;
      end
      bsfb_pkg::PH_ABORT: begin
        emit.last_of_run = 1'b1;
        emit.frame_end   = 1'b1;
        emit.aborted     = 1'b1;
      end
      default: begin
        emit = '0;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bsfb_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (advance) begin
      frm_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step) begin
      frm_item <= emit;
    end
  end

endmodule

@@ design/byte_stuffed_frame_builder_core.sv @@
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder_core
// STX/ETX/DLE byte-stuffing framer with checksum and length limit.
// ----------------------------------------------------------------------------
// The payload side takes one item per cycle while the command queue
// (QUEUE_DEPTH entries) has room; the framed side emits one byte per cycle
// while the receiver does not stall it. An item gives its byte, with STX
// before it on the first byte, DLE before it on a control byte, and the
// checksum and ETX after it on the last byte; bytes past the limit give none,
// and an overlong packet gives a single abort byte at its end. The emit
// sequencer's one byte per cycle sets the sustained rate. The max_length
// register is written through cfg_valid/cfg_ready; the user must write it only
// while the block is idle, which the block itself does not enforce. The limit
// in force is the smaller of max_length and MAX_PAYLOAD.
module byte_stuffed_frame_builder_core #(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pay_valid,
  output logic                pay_stall,
  input  bsfb_pkg::pay_item_t pay_item,
  output logic                frm_valid,
  input  logic                frm_stall,
  output bsfb_pkg::frm_item_t frm_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam int unsigned LIMIT_CAP = (MAX_PAYLOAD > 255) ? 255 : MAX_PAYLOAD;

  logic [7:0]          max_length;
  logic [7:0]          limit;
  logic                push;
  logic                pop;
  bsfb_pkg::cmd_t      wr_cmd;
  bsfb_pkg::cmd_t      head_cmd;
  bsfb_pkg::q_stat_t   q_stat;

  // length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= bsfb_pkg::MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  // limit in force
  assign limit = (max_length > 8'(LIMIT_CAP)) ? 8'(LIMIT_CAP) : max_length;

  bsfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pay_valid (pay_valid),
    .pay_stall (pay_stall),
    .pay_item  (pay_item),
    .limit     (limit),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (wr_cmd)
  );

  bsfb_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .q_stat (q_stat)
  );

  bsfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .frm_valid (frm_valid),
    .frm_stall (frm_stall),
    .frm_item  (frm_item)
  );

  // an abort item closes the frame alone with a zero byte
  a_abort_shape: assert property (@(posedge clk) disable iff (rst)
    frm_valid && frm_item.aborted |->
      frm_item.frame_end && frm_item.last_of_run && (frm_item.out_byte == 8'd0))
    else $error("abort item malformed");

  // frame end is always the last byte of its item
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    frm_valid && frm_item.frame_end |-> frm_item.last_of_run)
    else $error("frame end not last of run");

  // the queue is never pushed while full nor popped while empty
  a_queue_safe: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full) && !(pop && q_stat.empty))
    else $error("command queue overrun or underrun");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-stuffed frame builder.
// A queue-fed driver offers payload items and a checker predicts the framed
// byte stream (STX, DLE escapes, checksum, ETX, length aborts) for each
// accepted item. It compares every output item in order. Both sides idle in
// random bursts, the receiver holds off once for a long stretch, and the
// length register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_PAYLOAD   = 255;
  localparam int SETTLE_CYCLES = 20;
  localparam int STUCK_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                pay_valid = 1'b0;
  logic                pay_stall;
  bsfb_pkg::pay_item_t pay_item = '0;
  logic                frm_valid;
  logic                frm_stall;
  bsfb_pkg::frm_item_t frm_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = '0;

  // receiver stall sources
  logic rx_stall = 1'b0;
  logic rx_hold  = 1'b0;
  assign frm_stall = rx_stall | rx_hold;

  // items waiting to be offered, framed bytes waiting to be seen
  bsfb_pkg::pay_item_t pay_pending [$];
  bsfb_pkg::frm_item_t frm_expected [$];

  // predicted packet state and length register
  logic       pkt_open  = 1'b0;
  logic [7:0] pkt_count = '0;
  logic [7:0] pkt_sum   = '0;
  logic       pkt_over  = 1'b0;
  logic [7:0] len_limit = bsfb_pkg::MAX_LENGTH_RESET;

  // idling control, set per phase
  int  tx_odds = 0;
  int  rx_odds = 0;
  bit  quiet = 1'b0;
  bit  hold_armed = 1'b0;
  bit  hold_used = 1'b0;
  int  tx_gap = 0;
  int  rx_burst = 0;
  int  hold_cnt = 0;
  int  stuck = 0;

  // run statistics
  int unsigned n_pay = 0;
  int unsigned n_frm = 0;
  int unsigned n_frames = 0;
  int unsigned n_aborts = 0;
  int unsigned n_escapes = 0;
  int unsigned n_errors = 0;

  byte_stuffed_frame_builder_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pay_valid(pay_valid),
    .pay_stall(pay_stall),
    .pay_item (pay_item),
    .frm_valid(frm_valid),
    .frm_stall(frm_stall),
    .frm_item (frm_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bsfb_pkg::frm_item_t frame_byte(input logic [7:0] b,
                                                     input logic fend,
                                                     input logic abrt);
    bsfb_pkg::frm_item_t r;
    r.out_byte    = b;
    r.last_of_run = 1'b0;
    r.frame_end   = fend;
    r.aborted     = abrt;
    return r;
  endfunction

  // framed bytes caused by one accepted payload item
  task automatic stuff_payload_byte(input bsfb_pkg::pay_item_t it);
    bsfb_pkg::frm_item_t run [5];
    int                  n;
    int                  lim;
    logic [7:0]          b;
    n = 0;
    b = it.data_byte;
    lim = (MAX_PAYLOAD < int'(len_limit)) ? MAX_PAYLOAD : int'(len_limit);
    if (pkt_over || int'(pkt_count) >= lim) begin
      // overlong packet: drop bytes, one abort item at its end
      pkt_over = 1'b1;
      if (it.end_of_packet) begin
        run[n] = frame_byte(8'h00, 1'b1, 1'b1);
        n++;
        n_aborts++;
        pkt_open = 1'b0; pkt_count = '0; pkt_sum = '0; pkt_over = 1'b0;
      end
    end else begin
      if (!pkt_open) begin
        run[n] = frame_byte(bsfb_pkg::STX, 1'b0, 1'b0);
        n++;
        pkt_open = 1'b1;
      end
      if (b == bsfb_pkg::DLE || b == bsfb_pkg::STX || b == bsfb_pkg::ETX) begin
        run[n] = frame_byte(bsfb_pkg::DLE, 1'b0, 1'b0);
        n++;
        n_escapes++;
      end
      run[n] = frame_byte(b, 1'b0, 1'b0);
      n++;
      pkt_sum   = pkt_sum + b;
      pkt_count = pkt_count + 8'd1;
      if (it.end_of_packet) begin
        run[n] = frame_byte(~pkt_sum, 1'b0, 1'b0);
        n++;
        run[n] = frame_byte(bsfb_pkg::ETX, 1'b1, 1'b0);
        n++;
        n_frames++;
        pkt_open = 1'b0; pkt_count = '0; pkt_sum = '0; pkt_over = 1'b0;
      end
    end
    if (n > 0) run[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) frm_expected.push_back(run[i]);
  endtask

  // payload driver: holds an item until taken, random gaps between items
  always @(posedge clk) begin
    if (rst) begin
      pay_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (pay_valid && !pay_stall) begin
        stuff_payload_byte(pay_item);
        n_pay++;
      end
      if (!pay_valid || !pay_stall) begin
        if (tx_gap != 0) begin
          tx_gap--;
          pay_valid <= 1'b0;
        end else if (pay_pending.size() != 0) begin
          pay_item  <= pay_pending.pop_front();
          pay_valid <= 1'b1;
          if (!quiet && tx_odds != 0 && $urandom_range(1, tx_odds) == 1)
            tx_gap = $urandom_range(1, 19);
        end else begin
          pay_valid <= 1'b0;
        end
      end
    end
  end

  // frame checker and receiver stall bursts
  always @(posedge clk) begin
    if (!rst && frm_valid && !frm_stall) begin
      n_frm++;
      if (frm_expected.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: unexpected item byte=%02h last=%b end=%b abort=%b",
                   frm_item.out_byte, frm_item.last_of_run, frm_item.frame_end,
                   frm_item.aborted);
      end else begin
        if (frm_item.out_byte !== frm_expected[0].out_byte ||
            frm_item.last_of_run !== frm_expected[0].last_of_run ||
            frm_item.frame_end !== frm_expected[0].frame_end ||
            frm_item.aborted !== frm_expected[0].aborted) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("ERROR: item %0d exp byte=%02h last=%b end=%b abort=%b",
                     n_frm, frm_expected[0].out_byte, frm_expected[0].last_of_run,
                     frm_expected[0].frame_end, frm_expected[0].aborted);
            $display("       got byte=%02h last=%b end=%b abort=%b",
                     frm_item.out_byte, frm_item.last_of_run, frm_item.frame_end,
                     frm_item.aborted);
          end
        end
        void'(frm_expected.pop_front());
      end
    end
    if (rx_burst != 0)
      rx_burst--;
    else if (!rst && !quiet && rx_odds != 0 && $urandom_range(1, rx_odds) == 1)
      rx_burst = $urandom_range(1, 19);
    rx_stall <= (rx_burst != 0);
  end

  // long receiver hold-off so the input side backs up
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt--;
      rx_hold <= (hold_cnt != 0);
    end else if (hold_armed && !hold_used) begin
      hold_used = 1'b1;
      hold_cnt  = HOLD_CYCLES;
      rx_hold  <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (pay_valid && !pay_stall) || (frm_valid && !frm_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("ERROR: no progress for %0d cycles, %0d items still expected",
                 stuck, frm_expected.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return bsfb_pkg::DLE;
      1: return bsfb_pkg::STX;
      2: return bsfb_pkg::ETX;
      3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eop);
    bsfb_pkg::pay_item_t it;
    it.data_byte     = b;
    it.end_of_packet = eop;
    pay_pending.push_back(it);
  endtask

  task automatic queue_packet(input int len);
    for (int i = 0; i < len; i++) add_byte(pick_byte(), i == len - 1);
  endtask

  // mostly well-formed packets, some past the limit
  task automatic random_phase(input int lim, input int n_items);
    int added;
    int len;
    int cap;
    added = 0;
    cap = (lim < 12) ? lim : 12;
    while (added < n_items) begin
      if (lim == 0)
        len = $urandom_range(1, 3);
      else if (lim < 16 && $urandom_range(0, 4) == 0)
        len = lim + $urandom_range(1, 3);
      else
        len = $urandom_range(1, cap);
      queue_packet(len);
      added += len;
    end
  endtask

  task automatic pick_idling();
    tx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
    rx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
  endtask

  // wait until every item is out, then let dropped bytes clear the block
  task automatic drain_and_settle();
    while (pay_pending.size() != 0 || pay_valid || frm_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_limit = v;
  endtask

  // stimulus sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset length: single bytes, control bytes, checksum corners
    tx_odds = 3;
    rx_odds = 3;
    add_byte(8'h00, 1'b1);
    add_byte(bsfb_pkg::DLE, 1'b1);
    add_byte(bsfb_pkg::STX, 1'b0);
    add_byte(bsfb_pkg::ETX, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h55, 1'b1);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h11, 1'b0);
    add_byte(8'h0F, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h04, 1'b1);
    add_byte(bsfb_pkg::DLE, 1'b0);
    add_byte(bsfb_pkg::DLE, 1'b1);
    drain_and_settle();

    // limit of one: one byte fits, longer packets abort
    write_max_length(8'd1);
    add_byte(bsfb_pkg::ETX, 1'b1);
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b0);
    add_byte(8'h43, 1'b1);
    add_byte(bsfb_pkg::DLE, 1'b0);
    add_byte(8'h20, 1'b1);
    drain_and_settle();

    // zero limit: every packet aborts, no start byte
    write_max_length(8'd0);
    add_byte(8'h55, 1'b1);
    add_byte(bsfb_pkg::DLE, 1'b0);
    add_byte(bsfb_pkg::STX, 1'b1);
    drain_and_settle();

    // largest limit
    write_max_length(8'd255);
    pick_idling();
    random_phase(255, 14);
    drain_and_settle();

    // receiver holds off while the sender keeps offering
    write_max_length(8'd3);
    pick_idling();
    random_phase(3, 18);
    hold_armed = 1'b1;
    drain_and_settle();

    write_max_length(8'd1);
    pick_idling();
    random_phase(1, 14);
    drain_and_settle();

    write_max_length(8'($urandom_range(2, 20)));
    pick_idling();
    random_phase(int'(len_limit), 16);
    drain_and_settle();

    // closing stretch at full rate
    quiet = 1'b1;
    write_max_length(8'($urandom_range(4, 40)));
    random_phase(int'(len_limit), 16);
    drain_and_settle();

    $display("covered %0d payload items and %0d framed bytes: %0d frames, %0d aborts,",
             n_pay, n_frm, n_frames, n_aborts);
    $display("%0d escaped bytes, length limits 0, 1, 3 and 255, %0d mismatches",
             n_escapes, n_errors);
    if (n_errors == 0 && frm_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
